// ===== rtl/sha_pkg.sv =====
`timescale 1ns / 1ps

package sha_pkg;

  // Eight 32-bit words; index 0 is the first word (a, or H0).
  typedef logic [7:0][31:0] sha_words_t;

  // Controls for the byte window / message schedule.
  typedef struct packed {
    logic byte_en;   // shift one message byte in
    logic word_en;   // advance the schedule by one word
  } sha_sched_ctrl_t;

  // Controls for the round unit.
  typedef struct packed {
    logic load;      // load working variables from the chaining value
    logic step;      // run one compression round
  } sha_rnd_ctrl_t;

  localparam logic [7:0]  PAD_BYTE   = 8'h80;
  localparam logic [2:0]  LEN_SLOT   = 3'd7;     // byte positions 56..63
  localparam logic [63:0] BLOCK_BITS = 64'd512;

  function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} >> n;
    return d[31:0];
  endfunction

  function automatic logic [31:0] sha_iv(input logic [2:0] i);
    case (i)
      3'd0: return 32'h6a09e667;
      3'd1: return 32'hbb67ae85;
      3'd2: return 32'h3c6ef372;
      3'd3: return 32'ha54ff53a;
      3'd4: return 32'h510e527f;
      3'd5: return 32'h9b05688c;
      3'd6: return 32'h1f83d9ab;
      3'd7: return 32'h5be0cd19;
      default: return 32'h0;
    endcase
  endfunction

  function automatic logic [31:0] sha_k(input logic [5:0] t);
    case (t)
      6'd0:  return 32'h428a2f98;  6'd1:  return 32'h71374491;
      6'd2:  return 32'hb5c0fbcf;  6'd3:  return 32'he9b5dba5;
      6'd4:  return 32'h3956c25b;  6'd5:  return 32'h59f111f1;
      6'd6:  return 32'h923f82a4;  6'd7:  return 32'hab1c5ed5;
      6'd8:  return 32'hd807aa98;  6'd9:  return 32'h12835b01;
      6'd10: return 32'h243185be;  6'd11: return 32'h550c7dc3;
      6'd12: return 32'h72be5d74;  6'd13: return 32'h80deb1fe;
      6'd14: return 32'h9bdc06a7;  6'd15: return 32'hc19bf174;
      6'd16: return 32'he49b69c1;  6'd17: return 32'hefbe4786;
      6'd18: return 32'h0fc19dc6;  6'd19: return 32'h240ca1cc;
      6'd20: return 32'h2de92c6f;  6'd21: return 32'h4a7484aa;
      6'd22: return 32'h5cb0a9dc;  6'd23: return 32'h76f988da;
      6'd24: return 32'h983e5152;  6'd25: return 32'ha831c66d;
      6'd26: return 32'hb00327c8;  6'd27: return 32'hbf597fc7;
      6'd28: return 32'hc6e00bf3;  6'd29: return 32'hd5a79147;
      6'd30: return 32'h06ca6351;  6'd31: return 32'h14292967;
      6'd32: return 32'h27b70a85;  6'd33: return 32'h2e1b2138;
      6'd34: return 32'h4d2c6dfc;  6'd35: return 32'h53380d13;
      6'd36: return 32'h650a7354;  6'd37: return 32'h766a0abb;
      6'd38: return 32'h81c2c92e;  6'd39: return 32'h92722c85;
      6'd40: return 32'ha2bfe8a1;  6'd41: return 32'ha81a664b;
      6'd42: return 32'hc24b8b70;  6'd43: return 32'hc76c51a3;
      6'd44: return 32'hd192e819;  6'd45: return 32'hd6990624;
      6'd46: return 32'hf40e3585;  6'd47: return 32'h106aa070;
      6'd48: return 32'h19a4c116;  6'd49: return 32'h1e376c08;
      6'd50: return 32'h2748774c;  6'd51: return 32'h34b0bcb5;
      6'd52: return 32'h391c0cb3;  6'd53: return 32'h4ed8aa4a;
      6'd54: return 32'h5b9cca4f;  6'd55: return 32'h682e6ff3;
      6'd56: return 32'h748f82ee;  6'd57: return 32'h78a5636f;
      6'd58: return 32'h84c87814;  6'd59: return 32'h8cc70208;
      6'd60: return 32'h90befffa;  6'd61: return 32'ha4506ceb;
      6'd62: return 32'hbef9a3f7;  6'd63: return 32'hc67178f2;
      default: return 32'h0;
    endcase
  endfunction

endpackage

// ===== rtl/sha256_byte_stream_hasher.sv =====
`timescale 1ns / 1ps

// Channel | Dir | Signals                     | Request carries
// s_*     | in  | tvalid tready tdata tuser   | tdata[7:0] data_byte; tuser func
// m_*     | out | tvalid tready tdata tlast   | tdata[31:0] digest_word,
//         |     |                             | tdata[34:32] word_index; tlast last
//
// The 64th byte of a block starts a compression: the rounds on the shared
// round unit (ST_COMP), then a fold (ST_FOLD), with s_tready low. A finish
// request feeds padding one byte per cycle up to the
// end of the block (one or two blocks), compresses each, then offers eight
// digest words, one per accepted output request. Reset (rst, synchronous)
// loads the SHA-256 initial value and clears counts; m_tready low holds the
// current word without loss.
module sha256_byte_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] data_byte
  input  logic        s_tuser,    // [0] func: 0 absorb, 1 finish
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,    // [31:0] digest_word, [34:32] word_index, zero fill
  output logic        m_tlast     // last digest word
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PAD  = 3'd1;
  localparam logic [2:0] ST_COMP = 3'd2;
  localparam logic [2:0] ST_FOLD = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]          state;
  logic [5:0]          fill;       // byte position in the current block
  logic [63:0]         length;     // bits in completed blocks
  logic [63:0]         total;      // message length, shifted out MSB first
  logic [5:0]          rnd;
  logic [2:0]          out_idx;
  logic                fin;        // compression belongs to a finish
  logic                pad_first;  // next pad byte is the 0x80 marker
  logic                len_ok;     // length fits in this block
  sha_pkg::sha_words_t h;
  sha_pkg::sha_words_t v;

  sha_pkg::sha_sched_ctrl_t sched_ctrl;
  sha_pkg::sha_rnd_ctrl_t   rnd_ctrl;
  logic [7:0]               byte_in;
  logic [7:0]               pad_byte;
  logic [31:0]              w_cur;
  logic                     s_fire, m_fire, len_byte;

  assign s_tready = (state == ST_IDLE);
  assign s_fire   = s_tvalid && s_tready;
  assign m_tvalid = (state == ST_OUT);
  assign m_fire   = m_tvalid && m_tready;
  assign m_tdata  = {5'd0, out_idx, h[0]};
  assign m_tlast  = (out_idx == 3'd7);

  // Pad byte: marker first, then zeros, then the length in the last eight slots.
  assign len_byte = !pad_first && len_ok && (fill[5:3] == sha_pkg::LEN_SLOT);
  always_comb begin
    if (pad_first) begin
      pad_byte = sha_pkg::PAD_BYTE;
    end else if (len_byte) begin
      pad_byte = total[63:56];
    end else begin
      pad_byte = 8'd0;
    end
  end

  assign byte_in            = (state == ST_PAD) ? pad_byte : s_tdata;
  assign sched_ctrl.byte_en = (s_fire && !s_tuser) || (state == ST_PAD);
  assign sched_ctrl.word_en = (state == ST_COMP);
  assign rnd_ctrl.load      = (s_fire && !s_tuser && fill == 6'd63)
                           || (state == ST_PAD && fill == 6'd63);
  assign rnd_ctrl.step      = (state == ST_COMP);

  sha_sched u_sched (
    .clk     (clk),
    .ctrl    (sched_ctrl),
    .byte_in (byte_in),
    .w_cur   (w_cur)
  );

  sha_round u_round (
    .clk    (clk),
    .ctrl   (rnd_ctrl),
    .h_init (h),
    .w      (w_cur),
    .k      (sha_pkg::sha_k(rnd)),
    .v      (v)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= 6'd0;
      length    <= 64'd0;
      rnd       <= 6'd0;
      out_idx   <= 3'd0;
      fin       <= 1'b0;
      pad_first <= 1'b0;
      len_ok    <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        h[i] <= sha_pkg::sha_iv(3'(i));
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_fire) begin
            if (s_tuser) begin
              // Capture the message length, start padding.
              total     <= length + {55'd0, fill, 3'd0};
              fin       <= 1'b1;
              pad_first <= 1'b1;
              state     <= ST_PAD;
            end else begin
              fill <= fill + 6'd1;
              if (fill == 6'd63) begin
                fin   <= 1'b0;
                rnd   <= 6'd0;
                state <= ST_COMP;
              end
            end
          end
        end
        ST_PAD: begin
          fill <= fill + 6'd1;
          if (pad_first) begin
            pad_first <= 1'b0;
            len_ok    <= (fill[5:3] != sha_pkg::LEN_SLOT);
          end
          if (len_byte) begin
            total <= {total[55:0], 8'd0};
          end
          if (fill == 6'd63) begin
            rnd   <= 6'd0;
            state <= ST_COMP;
          end
        end
        ST_COMP: begin
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) begin
            state <= ST_FOLD;
          end
        end
        ST_FOLD: begin
          for (int i = 0; i < 8; i++) begin
            h[i] <= h[i] + v[i];
          end
          if (!fin) begin
            length <= length + sha_pkg::BLOCK_BITS;
            state  <= ST_IDLE;
          end else if (len_ok) begin
            out_idx <= 3'd0;
            state   <= ST_OUT;
          end else begin
            // Length did not fit: one more block of zeros and length.
            len_ok <= 1'b1;
            state  <= ST_PAD;
          end
        end
        ST_OUT: begin
          if (m_fire) begin
            if (out_idx == 3'd7) begin
              // Digest delivered: start a new message.
              for (int i = 0; i < 8; i++) begin
                h[i] <= sha_pkg::sha_iv(3'(i));
              end
              fill   <= 6'd0;
              length <= 64'd0;
              fin    <= 1'b0;
              state  <= ST_IDLE;
            end else begin
              for (int i = 0; i < 7; i++) begin
                h[i] <= h[i+1];
              end
              out_idx <= out_idx + 3'd1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/sha_sched.sv =====
`timescale 1ns / 1ps

// 64-byte window. Bytes shift in at the low end; during compression the
// same register rolls one word per round and appends the expanded word.
module sha_sched (
  input  logic                     clk,
  input  sha_pkg::sha_sched_ctrl_t ctrl,
  input  logic [7:0]               byte_in,
  output logic [31:0]              w_cur
);

  logic [511:0] win;
  logic [31:0]  w1, w9, w14, s0, s1, w_new;

  assign w_cur = win[511:480];
  assign w1    = win[479:448];
  assign w9    = win[223:192];
  assign w14   = win[63:32];

  assign s0    = sha_pkg::rotr(w1, 5'd7) ^ sha_pkg::rotr(w1, 5'd18) ^ (w1 >> 3);
  assign s1    = sha_pkg::rotr(w14, 5'd17) ^ sha_pkg::rotr(w14, 5'd19) ^ (w14 >> 10);
  assign w_new = s1 + w9 + s0 + w_cur;

  always_ff @(posedge clk) begin
    if (ctrl.byte_en) begin
      win <= {win[503:0], byte_in};
    end else if (ctrl.word_en) begin
      win <= {win[479:0], w_new};
    end
  end

endmodule

// ===== rtl/sha_round.sv =====
`timescale 1ns / 1ps

// Working variables a..h and one SHA-256 round per step.
module sha_round (
  input  logic                   clk,
  input  sha_pkg::sha_rnd_ctrl_t ctrl,
  input  sha_pkg::sha_words_t    h_init,
  input  logic [31:0]            w,
  input  logic [31:0]            k,
  output sha_pkg::sha_words_t    v
);

  logic [31:0] t1, t2, big_s0, big_s1, ch, maj;

  assign big_s1 = sha_pkg::rotr(v[4], 5'd6) ^ sha_pkg::rotr(v[4], 5'd11)
                ^ sha_pkg::rotr(v[4], 5'd25);
  assign ch     = (v[4] & v[5]) ^ (~v[4] & v[6]);
  assign big_s0 = sha_pkg::rotr(v[0], 5'd2) ^ sha_pkg::rotr(v[0], 5'd13)
                ^ sha_pkg::rotr(v[0], 5'd22);
  assign maj    = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
  assign t1     = v[7] + big_s1 + ch + k + w;
  assign t2     = big_s0 + maj;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      v <= h_init;
    end else if (ctrl.step) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

endmodule
